FILE: hdl/efi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efi_pkg;

  localparam int SQ_W  = 63;
  localparam int MAG_W = 36;
  localparam logic [SQ_W-1:0] SQ_CAP = {1'b1, {(SQ_W-1){1'b0}}};

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_JRE   = 2'd2;
  localparam logic [1:0] REG_JIM   = 2'd3;

  localparam logic [1:0] MODE_MANDEL = 2'd0;
  localparam logic [1:0] MODE_JULIA  = 2'd1;
  localparam logic [1:0] MODE_SHIP   = 2'd2;

  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_MUL  = 2'd1;
  localparam step_t STEP_EVAL = 2'd2;

  typedef enum logic [1:0] {
    COND_NEXT    = 2'd0,
    COND_WAIT_IN = 2'd1,
    COND_TEST    = 2'd2
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  mul;
    logic  eval;
    cond_t cond;
    step_t next_step;
    step_t jump_step;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic slot_free;
    logic finished;
  } efi_status_t;

  typedef struct packed {
    logic take_in;
    logic load;
    logic mul;
    logic update;
    logic commit;
  } efi_ctrl_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '{take_in: 1'b0, mul: 1'b0, eval: 1'b0, cond: COND_NEXT,
          next_step: STEP_IDLE, jump_step: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.take_in   = 1'b1;
        w.cond      = COND_WAIT_IN;
        w.next_step = STEP_MUL;
      end
      STEP_MUL: begin
        w.mul       = 1'b1;
        w.next_step = STEP_EVAL;
      end
      STEP_EVAL: begin
        w.eval      = 1'b1;
        w.cond      = COND_TEST;
        w.next_step = STEP_MUL;
        w.jump_step = STEP_IDLE;
      end
      default: begin
        w.next_step = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/efi_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module efi_useq (
  input  wire                  clk,
  input  wire                  rst,
  input  efi_pkg::efi_status_t status,
  output efi_pkg::efi_ctrl_t   ctrl
);
  import efi_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t word;

  assign word = ucode(step);

  always_comb begin
    case (word.cond)
      COND_NEXT:    step_next = word.next_step;
      COND_WAIT_IN: step_next = status.in_valid ? word.next_step : step;
      COND_TEST: begin
        if (!status.finished) begin
          step_next = word.next_step;
        end else if (status.slot_free) begin
          step_next = word.jump_step;
        end else begin
          step_next = step;
        end
      end
      default:      step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl.take_in = word.take_in;
    ctrl.load    = word.take_in & status.in_valid;
    ctrl.mul     = word.mul;
    ctrl.update  = word.eval & ~status.finished;
    ctrl.commit  = word.eval & status.finished & status.slot_free;
  end

endmodule

`default_nettype wire

FILE: hdl/efi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module efi_datapath #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 10
) (
  input  wire                               clk,
  input  efi_pkg::efi_ctrl_t                ctrl,
  input  wire        [1:0]                  fractal_mode,
  input  wire        [COUNT_WIDTH-1:0]      iteration_limit,
  input  wire signed [COORD_WIDTH-1:0]      julia_re,
  input  wire signed [COORD_WIDTH-1:0]      julia_im,
  input  wire signed [COORD_WIDTH-1:0]      point_re,
  input  wire signed [COORD_WIDTH-1:0]      point_im,
  output logic                              finished,
  output logic       [COUNT_WIDTH-1:0]      iter_count,
  output logic       [efi_pkg::MAG_W-1:0]   final_mag_sq
);
  import efi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW;
  localparam int XW = (PW > 64) ? PW : 64;
  localparam int SW = SQ_W + 3;
  localparam logic [63:0] ESC_LEVEL = 64'(4) << FRAC_BITS;
  localparam logic [63:0] MAG_MAX   = {{(64-MAG_W){1'b0}}, {MAG_W{1'b1}}};
  localparam logic signed [SW-1:0] C_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] C_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + CW'(1)) : v;
  endfunction

  function automatic logic [SQ_W-1:0] scale(input logic [PW-1:0] p, input int sh);
    logic [XW-1:0] px;
    logic [XW-1:0] ps;
    px = XW'(p);
    ps = px >> sh;
    if ((px >> 64) != '0 || ps > XW'(SQ_CAP)) begin
      return SQ_CAP;
    end
    return SQ_W'(ps);
  endfunction

  function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
    if (v > C_MAX) begin
      return {1'b0, {(CW-1){1'b1}}};
    end
    if (v < C_MIN) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return v[CW-1:0];
  endfunction

  logic [CW-1:0]          zr, zi, cr, ci;
  logic                   ship;
  logic [COUNT_WIDTH-1:0] n;
  logic [PW-1:0]          p_rr, p_ii, p_ri;

  logic [SQ_W-1:0]        sr, si, sx;
  logic [63:0]            mag_sum;
  logic                   escape;
  logic                   neg;
  logic signed [SW-1:0]   re_sum, im_sum, cross_s;
  logic [CW-1:0]          zr_next, zi_next;

  always_comb begin
    sr      = scale(p_rr, FRAC_BITS);
    si      = scale(p_ii, FRAC_BITS);
    sx      = scale(p_ri, FRAC_BITS - 1);
    mag_sum = 64'(sr) + 64'(si);
    escape  = mag_sum >= ESC_LEVEL;
    finished = escape || (n >= iteration_limit);
    neg     = (zr[CW-1] != zi[CW-1]) && !ship;
    re_sum  = $signed({3'b000, sr}) - $signed({3'b000, si})
              + $signed({{(SW-CW){cr[CW-1]}}, cr});
    cross_s = neg ? -$signed({3'b000, sx}) : $signed({3'b000, sx});
    im_sum  = cross_s + $signed({{(SW-CW){ci[CW-1]}}, ci});
    zr_next = sat(re_sum);
    zi_next = sat(im_sum);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      zr   <= point_re;
      zi   <= point_im;
      n    <= '0;
      ship <= (fractal_mode == MODE_SHIP);
      if (fractal_mode == MODE_JULIA) begin
        cr <= julia_re;
        ci <= julia_im;
      end else begin
        cr <= point_re;
        ci <= point_im;
      end
    end else if (ctrl.update) begin
      zr <= zr_next;
      zi <= zi_next;
      n  <= n + COUNT_WIDTH'(1);
    end
    if (ctrl.mul) begin
      p_rr <= PW'(mag_of(zr)) * PW'(mag_of(zr));
      p_ii <= PW'(mag_of(zi)) * PW'(mag_of(zi));
      p_ri <= PW'(mag_of(zr)) * PW'(mag_of(zi));
    end
    if (ctrl.commit) begin
      iter_count   <= n;
      final_mag_sq <= (mag_sum > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : mag_sum[MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/escape_time_fractal_iterator.sv
// Escape-time fractal iterator: Mandelbrot, Julia and Burning Ship.
// Input channel (in_valid/in_ready) carries one complex point in signed
// fixed point; the output channel (out_valid/out_ready) returns the step
// count and the final |z|^2, saturated to 36 bits.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// mode, iteration limit and the Julia constant; it is always ready.
// A short microprogram runs the datapath: one step takes the point, then
// each iteration is two steps, one for the three registered products and
// one for the escape test and the z update.
// A point is iterated until it escapes or reaches the iteration limit, and
// no new point is taken meanwhile; the sequencer returns to its idle step
// as the result is registered, so the next point can be taken on the cycle
// after.
// The result sits in an output register; a new point is accepted while it
// waits. If the receiver stalls and a second result is ready, the
// sequencer holds that result in its test step until the register frees.
// Reset returns the sequencer to its idle step, drops out_valid and loads
// mode Mandelbrot, limit 201 and a zero Julia constant.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_iterator #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 10
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire        [1:0]                cfg_index,
  input  wire        [COORD_WIDTH-1:0]    cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire signed [COORD_WIDTH-1:0]    point_re,
  input  wire signed [COORD_WIDTH-1:0]    point_im,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic       [COUNT_WIDTH-1:0]    iter_count,
  output logic       [efi_pkg::MAG_W-1:0] final_mag_sq
);
  import efi_pkg::*;

  logic [1:0]              fractal_mode;
  logic [COUNT_WIDTH-1:0]  iteration_limit;
  logic [COORD_WIDTH-1:0]  julia_re;
  logic [COORD_WIDTH-1:0]  julia_im;

  efi_status_t status;
  efi_ctrl_t   ctrl;
  logic        finished;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.take_in;

  always_comb begin
    status.in_valid  = in_valid;
    status.slot_free = ~out_valid | out_ready;
    status.finished  = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fractal_mode    <= MODE_MANDEL;
      iteration_limit <= COUNT_WIDTH'(201);
      julia_re        <= '0;
      julia_im        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:  fractal_mode    <= cfg_data[1:0];
        REG_LIMIT: iteration_limit <= cfg_data[COUNT_WIDTH-1:0];
        REG_JRE:   julia_re        <= cfg_data;
        REG_JIM:   julia_im        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  efi_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  efi_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .ctrl            (ctrl),
    .fractal_mode    (fractal_mode),
    .iteration_limit (iteration_limit),
    .julia_re        (julia_re),
    .julia_im        (julia_im),
    .point_re        (point_re),
    .point_im        (point_im),
    .finished        (finished),
    .iter_count      (iter_count),
    .final_mag_sq    (final_mag_sq)
  );

endmodule

`default_nettype wire

FILE: hdl/efi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module efi_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int COUNT_WIDTH = 10
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          cfg_ready,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [COUNT_WIDTH-1:0]        iter_count,
  input wire [efi_pkg::MAG_W-1:0]     final_mag_sq
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(iter_count) && $stable(final_mag_sq))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("point accepted while busy");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> in_ready)
    else $error("result posted without returning to idle");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !(out_valid && !$past(out_valid)))
    else $error("result too soon after acceptance");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> cfg_ready)
    else $error("configuration port blocked while idle");

endmodule

bind escape_time_fractal_iterator efi_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_efi_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_ready    (cfg_ready),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .iter_count   (iter_count),
  .final_mag_sq (final_mag_sq)
);

`default_nettype wire

FILE: dv/escape_checker.sv
`timescale 1ns / 1ps

module escape_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [31:0]               point_re,
  input  logic [31:0]               point_im,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [9:0]                iter_count,
  input  logic [efi_pkg::MAG_W-1:0] final_mag_sq,
  output int                        errors,
  output int                        pending
);
  import efi_pkg::*;

  localparam int          FRAC      = 28;
  localparam logic [63:0] ESCAPE_AT = 64'd4 << FRAC;
  localparam longint      Z_MAX     = 64'sd2147483647;
  localparam longint      Z_MIN     = -64'sd2147483648;
  localparam logic [63:0] MAG_TOP   = (64'd1 << MAG_W) - 64'd1;

  typedef struct packed {
    logic [9:0]       count;
    logic [MAG_W-1:0] mag;
  } escape_t;

  logic [1:0]  mode_q;
  logic [9:0]  limit_q;
  logic [31:0] jre_q;
  logic [31:0] jim_q;
  escape_t     expected_escapes[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int unsigned sh);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> sh;
    return (p > 128'(SQ_CAP)) ? 64'(SQ_CAP) : p[63:0];
  endfunction

  function automatic logic [63:0] square_of(input longint v);
    return scaled_product(magnitude(v), magnitude(v), FRAC);
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > Z_MAX) return Z_MAX;
    if (v < Z_MIN) return Z_MIN;
    return v;
  endfunction

  function automatic escape_t escape_iterate(input logic [31:0] pre, input logic [31:0] pim);
    longint      zr, zi, cr, ci, sr, si, xprod;
    logic [63:0] n, mag;
    logic        ship;
    escape_t     r;
    zr = $signed(pre);
    zi = $signed(pim);
    cr = zr;
    ci = zi;
    ship = (mode_q == MODE_SHIP);
    if (mode_q == MODE_JULIA) begin
      cr = $signed(jre_q);
      ci = $signed(jim_q);
    end
    n = 0;
    while (n < 64'(limit_q) && (square_of(zr) + square_of(zi)) < ESCAPE_AT) begin
      sr    = longint'(square_of(zr));
      si    = longint'(square_of(zi));
      xprod = longint'(scaled_product(magnitude(zr), magnitude(zi), FRAC - 1));
      if (!ship && ((zr < 0) != (zi < 0)))
        xprod = -xprod;
      zr = clamp_coord(sr - si + cr);
      zi = clamp_coord(xprod + ci);
      n++;
    end
    mag = square_of(zr) + square_of(zi);
    if (mag > MAG_TOP)
      mag = MAG_TOP;
    r.count = n[9:0];
    r.mag   = mag[MAG_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    escape_t got;
    escape_t want;
    if (rst) begin
      mode_q  = MODE_MANDEL;
      limit_q = 10'd201;
      jre_q   = '0;
      jim_q   = '0;
      expected_escapes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  mode_q  = cfg_data[1:0];
          REG_LIMIT: limit_q = cfg_data[9:0];
          REG_JRE:   jre_q   = cfg_data;
          REG_JIM:   jim_q   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_escapes.push_back(escape_iterate(point_re, point_im));
      if (out_valid && out_ready) begin
        got.count = iter_count;
        got.mag   = final_mag_sq;
        if (expected_escapes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result iter_count %0d final_mag_sq %h",
                     $realtime, got.count, got.mag);
        end else begin
          want = expected_escapes.pop_front();
          if (got.count != want.count || got.mag != want.mag) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch iter_count exp %0d got %0d, final_mag_sq exp %h got %h",
                       $realtime, want.count, got.count, want.mag, got.mag);
          end
        end
      end
    end
    pending = expected_escapes.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import efi_pkg::*;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index    = REG_MODE;
  logic [31:0]         cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [31:0]         point_re     = '0;
  logic [31:0]         point_im     = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [9:0]          iter_count;
  logic [MAG_W-1:0]    final_mag_sq;
  int                  errors;
  int                  pending;
  int                  tx_idle_pct  = 0;
  int                  rx_stall_pct = 0;

  escape_time_fractal_iterator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .point_re     (point_re),
    .point_im     (point_im),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .iter_count   (iter_count),
    .final_mag_sq (final_mag_sq)
  );

  escape_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .point_re     (point_re),
    .point_im     (point_im),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .iter_count   (iter_count),
    .final_mag_sq (final_mag_sq),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic push_point(input logic [31:0] re, input logic [31:0] im);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    point_re <= re;
    point_im <= im;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_iterator(input logic [31:0] mode, input logic [31:0] limit,
                                  input logic [31:0] jre, input logic [31:0] jim);
    wait_drained();
    write_reg(REG_MODE, mode);
    write_reg(REG_LIMIT, limit);
    write_reg(REG_JRE, jre);
    write_reg(REG_JIM, jim);
  endtask

  function automatic logic [31:0] pick_coord();
    int v;
    if ($urandom_range(9) < 8) begin
      v = int'($urandom_range(32'h5000_0000)) - 32'sh2800_0000;
      return 32'(v);
    end
    return $urandom;
  endfunction

  initial begin
    logic [31:0] mode_word;
    logic [31:0] limit;
    int          count;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: Mandelbrot, limit 201
    push_point(32'h0000_0000, 32'h0000_0000);
    push_point(32'h2000_0000, 32'h0000_0000);
    push_point(32'h1FFF_FFFF, 32'h0000_0000);
    push_point(32'hE000_0000, 32'h0000_0000);
    push_point(32'hF000_0000, 32'h0000_0000);
    push_point(32'h0000_0000, 32'h1000_0000);
    push_point(32'h0400_0000, 32'h0000_0000);
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_point(32'h8000_0000, 32'h8000_0000);
    push_point(32'h8000_0000, 32'h7FFF_FFFF);
    push_point(32'h7FFF_FFFF, 32'h8000_0000);

    program_iterator(32'(MODE_SHIP), 1023, 32'h0, 32'h0);
    push_point(32'hE400_0000, 32'hFF00_0000);
    push_point(32'h0800_0000, 32'hF800_0000);

    program_iterator(32'd3, 0, 32'h0, 32'h0);
    push_point(32'h0000_0000, 32'h0000_0000);
    push_point(32'h7FFF_FFFF, 32'h8000_0000);

    program_iterator(32'(MODE_JULIA), 1023, 32'hF333_3333, 32'h027D_F3B6);
    push_point(32'h0000_0000, 32'h0000_0000);
    push_point(32'h04CC_CCCD, 32'hFCCC_CCCD);

    program_iterator(32'(MODE_JULIA), 1, 32'h7FFF_FFFF, 32'h8000_0000);
    push_point(32'h0000_0000, 32'h0000_0000);
    push_point(32'h8000_0000, 32'h7FFF_FFFF);

    program_iterator(32'(MODE_MANDEL), 1, 32'h0, 32'h0);
    push_point(32'h0800_0000, 32'h0800_0000);

    for (int p = 0; p < 12; p++) begin
      mode_word = 32'($urandom_range(3));
      if ($urandom_range(1))
        mode_word[31:2] = 30'($urandom);
      case (p)
        5:       limit = 1023;
        9:       limit = 201;
        10:      limit = 0;
        default: limit = $urandom_range(1, 80);
      endcase
      if ($urandom_range(1))
        limit[31:10] = 22'($urandom);
      count = (p == 5) ? 8 : 82;
      program_iterator(mode_word, limit, pick_coord(), pick_coord());
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      for (int i = 0; i < count; i++)
        push_point(pick_coord(), pick_coord());
    end

    wait_drained();
    repeat (2100) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/efi_pkg.sv
hdl/efi_useq.sv
hdl/efi_datapath.sv
hdl/escape_time_fractal_iterator.sv
hdl/efi_checker.sv
dv/escape_checker.sv
dv/tb.sv
